// ----- src/mlsl_pkg.sv -----
// Shared types and constants for the MAC learning lookup unit.
package mlsl_pkg;

    localparam int NUM_PORTS   = 8;
    localparam int TABLE_DEPTH = 64;
    localparam int MAC_W       = 48;
    localparam int PORT_W      = 3;
    localparam int MASK_W      = 8;
    localparam int PCNT_W      = 4;

    localparam logic [PCNT_W-1:0] PORT_COUNT_RESET = PCNT_W'(8);
    localparam logic [PCNT_W-1:0] PORT_COUNT_MAX   = PCNT_W'(NUM_PORTS);

    // one table entry as handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  addr;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEARN,
        S_LOOK
    } t_state;

endpackage

// ----- src/mlsl_cell.sv -----
// One table entry: holds address and port, compares against the key, shifts on insert.
module mlsl_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  mlsl_pkg::t_entry                i_prev,
    input  logic [mlsl_pkg::MAC_W-1:0]      i_key,
    output mlsl_pkg::t_entry                o_entry,
    output logic                            o_match
);

    logic                          r_valid;
    logic [mlsl_pkg::MAC_W-1:0]    r_addr;
    logic [mlsl_pkg::PORT_W-1:0]   r_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_addr <= i_prev.addr;
            r_port <= i_prev.port;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.addr  = r_addr;
    assign o_entry.port  = r_port;
    assign o_match       = r_valid && (r_addr == i_key);

endmodule

// ----- src/mac_learning_switch_lookup_unit.sv -----
// Top level of the layer-2 learning lookup unit: sequencer, cell row and result register.
//
// Input channel: i_in_valid / o_in_stall with source MAC, destination MAC and
// ingress port; an item is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with egress mask and the known,
// learned and full flags; one result per item, in order.
// Config channel: i_cfg_valid / o_cfg_ready carries port_count; ready whenever
// out of reset. The user must write it only while no item is in flight; the
// block itself does not enforce this. The table is a row of TABLE_DEPTH cells.
// A learned source enters at cell 0 and every cell passes its entry to its
// neighbour, so the row stays packed. Each item has a source compare and learn
// state, then a destination compare state that loads the result register. A new
// item is taken only while idle or as the result loads, so the block takes no
// item before it is through with the last, set by the single compare port each
// cell has. While the result register is held by i_out_stall the block carries
// its current item through learning, then waits in the destination compare
// state and stalls its input. Reset (synchronous, active low) clears all valid
// bits, the sequencer and the output valid bit, sets port_count to 8, and needs no
// clearing pass. Input stall is high and config ready low while reset is asserted.
module mac_learning_switch_lookup_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mlsl_pkg::MAC_W-1:0]        i_source_mac,
    input  logic [mlsl_pkg::MAC_W-1:0]        i_dest_mac,
    input  logic [mlsl_pkg::PORT_W-1:0]       i_ingress_port,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mlsl_pkg::MASK_W-1:0]       o_egress_mask,
    output logic                              o_dest_known,
    output logic                              o_learned_new,
    output logic                              o_table_full,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mlsl_pkg::PCNT_W-1:0]       i_cfg_data
);

    localparam int DEPTH = mlsl_pkg::TABLE_DEPTH;

    mlsl_pkg::t_state r_state, n_state;

    logic [mlsl_pkg::MAC_W-1:0]   r_src, r_dst;
    logic [mlsl_pkg::PORT_W-1:0]  r_ingress;
    logic                         r_learned, r_full;
    logic [mlsl_pkg::PCNT_W-1:0]  r_port_count;

    logic                         r_out_valid;
    logic [mlsl_pkg::MASK_W-1:0]  r_mask;
    logic                         r_known, r_out_learned, r_out_full;

    mlsl_pkg::t_entry             entries [DEPTH];
    logic [DEPTH-1:0]             match;
    mlsl_pkg::t_entry             head;
    logic [mlsl_pkg::MAC_W-1:0]   key;
    logic                         shift;
    logic                         any_match;
    logic [mlsl_pkg::PORT_W-1:0]  hit_port;
    logic                         accept;
    logic                         out_load;
    logic [mlsl_pkg::PCNT_W-1:0]  active;
    logic [mlsl_pkg::MASK_W-1:0]  mask;

    assign key          = (r_state == mlsl_pkg::S_LEARN) ? r_src : r_dst;
    assign head.valid   = 1'b1;
    assign head.addr    = r_src;
    assign head.port    = r_ingress;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                mlsl_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_prev  (head),
                    .i_key   (key),
                    .o_entry (entries[g]),
                    .o_match (match[g])
                );
            end else begin : g_next
                mlsl_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_prev  (entries[g-1]),
                    .i_key   (key),
                    .o_entry (entries[g]),
                    .o_match (match[g])
                );
            end
        end
    endgenerate

    // addresses in the table are unique, so at most one cell matches
    always_comb begin
        hit_port = '0;
        for (int k = 0; k < DEPTH; k++) begin
            hit_port = hit_port | (entries[k].port & {mlsl_pkg::PORT_W{match[k]}});
        end
    end

    assign any_match = |match;
    assign shift     = (r_state == mlsl_pkg::S_LEARN) && !any_match
                       && !entries[DEPTH-1].valid;

    assign active = (r_port_count > mlsl_pkg::PORT_COUNT_MAX) ?
                    mlsl_pkg::PORT_COUNT_MAX : r_port_count;

    always_comb begin
        mask = '0;
        if (any_match) begin
            for (int j = 0; j < mlsl_pkg::MASK_W; j++) begin
                mask[j] = (hit_port == mlsl_pkg::PORT_W'(j));
            end
        end else begin
            for (int j = 0; j < mlsl_pkg::MASK_W; j++) begin
                mask[j] = (mlsl_pkg::PCNT_W'(j) < active)
                          && (r_ingress != mlsl_pkg::PORT_W'(j));
            end
        end
    end

    assign out_load   = (r_state == mlsl_pkg::S_LOOK) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || !((r_state == mlsl_pkg::S_IDLE) || out_load);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlsl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mlsl_pkg::S_IDLE: begin
                if (accept) n_state = mlsl_pkg::S_LEARN;
            end
            mlsl_pkg::S_LEARN: begin
                n_state = mlsl_pkg::S_LOOK;
            end
            mlsl_pkg::S_LOOK: begin
                if (out_load) n_state = accept ? mlsl_pkg::S_LEARN : mlsl_pkg::S_IDLE;
            end
            default: begin
                n_state = mlsl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src     <= i_source_mac;
            r_dst     <= i_dest_mac;
            r_ingress <= i_ingress_port;
        end
        if (r_state == mlsl_pkg::S_LEARN) begin
            r_learned <= shift;
            r_full    <= !any_match && entries[DEPTH-1].valid;
        end
        if (out_load) begin
            r_mask        <= mask;
            r_known       <= any_match;
            r_out_learned <= r_learned;
            r_out_full    <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_port_count <= mlsl_pkg::PORT_COUNT_RESET;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_port_count <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready   = i_rst_n;
    assign o_out_valid   = r_out_valid;
    assign o_egress_mask = r_mask;
    assign o_dest_known  = r_known;
    assign o_learned_new = r_out_learned;
    assign o_table_full  = r_out_full;

endmodule

// ----- src/mlsl_checker.sv -----
// Port-level checker for the MAC learning lookup unit, bound to the top level.
module mlsl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [mlsl_pkg::MASK_W-1:0]       o_egress_mask,
    input  logic                              o_dest_known,
    input  logic                              o_learned_new,
    input  logic                              o_table_full
);

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_egress_mask))
        else $error("result changed while stalled");

    // the cycle after an item is taken the block is busy learning
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // a hit forwards to exactly one port
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dest_known |-> $onehot(o_egress_mask))
        else $error("known destination without a single egress port");

    // learning and table full exclude each other
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_learned_new && o_table_full))
        else $error("learned and full flagged together");

endmodule

bind mac_learning_switch_lookup_unit mlsl_checker u_mlsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_egress_mask (o_egress_mask),
    .o_dest_known  (o_dest_known),
    .o_learned_new (o_learned_new),
    .o_table_full  (o_table_full)
);

// ----- verif/mac_learning_switch_lookup_unit_tb.sv -----
// Self-checking testbench for the MAC learning lookup unit: own forwarding predictor.
`timescale 1ns / 100ps

module mac_learning_switch_lookup_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_FRAMES   = 85;
    localparam int POOL_SIZE      = 96;

    typedef struct packed {
        logic [mlsl_pkg::MAC_W-1:0]  src;
        logic [mlsl_pkg::MAC_W-1:0]  dst;
        logic [mlsl_pkg::PORT_W-1:0] ingress;
    } t_frame_hdr;

    typedef struct packed {
        logic [mlsl_pkg::MASK_W-1:0] egress_mask;
        logic                        dest_known;
        logic                        learned_new;
        logic                        table_full;
    } t_fwd_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURST
    } t_stall_pattern;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic [mlsl_pkg::MAC_W-1:0]    i_source_mac   = '0;
    logic [mlsl_pkg::MAC_W-1:0]    i_dest_mac     = '0;
    logic [mlsl_pkg::PORT_W-1:0]   i_ingress_port = '0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic [mlsl_pkg::MASK_W-1:0]   o_egress_mask;
    logic                          o_dest_known;
    logic                          o_learned_new;
    logic                          o_table_full;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [mlsl_pkg::PCNT_W-1:0]   i_cfg_data     = '0;

    mac_learning_switch_lookup_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_source_mac   (i_source_mac),
        .i_dest_mac     (i_dest_mac),
        .i_ingress_port (i_ingress_port),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_egress_mask  (o_egress_mask),
        .o_dest_known   (o_dest_known),
        .o_learned_new  (o_learned_new),
        .o_table_full   (o_table_full),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the MAC table and the port count register
    logic [mlsl_pkg::MAC_W-1:0]    tbl_mac  [mlsl_pkg::TABLE_DEPTH];
    logic [mlsl_pkg::PORT_W-1:0]   mac_port [mlsl_pkg::TABLE_DEPTH];
    bit [mlsl_pkg::TABLE_DEPTH-1:0] mac_vld = '0;
    int                            mac_entries = 0;
    logic [mlsl_pkg::PCNT_W-1:0]   flood_port_count = mlsl_pkg::PORT_COUNT_RESET;

    t_frame_hdr  hdr_pending_q[$];
    t_fwd_result fwd_expected_q[$];
    logic [mlsl_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];

    t_frame_hdr  drv_hdr;
    t_frame_hdr  seen_hdr;
    t_fwd_result want;
    logic        hdr_taken = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    t_stall_pattern stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          idle_cycles = 0;

    int items_pushed = 0;
    int results_seen = 0;
    int err_count = 0;
    int cfg_writes = 0;
    int n_learned = 0;
    int n_full = 0;
    int n_hits = 0;
    int n_floods = 0;

    function automatic logic [mlsl_pkg::MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int find_mac(input logic [mlsl_pkg::MAC_W-1:0] mac);
        for (int k = 0; k < mlsl_pkg::TABLE_DEPTH; k++)
            if (mac_vld[k] && tbl_mac[k] == mac)
                return k;
        return -1;
    endfunction

    // learn first, then look up the destination in the updated table
    function automatic t_fwd_result predict_forwarding(input t_frame_hdr f);
        t_fwd_result r;
        int slot;
        int active;
        int flood;
        r = '0;
        if (find_mac(f.src) < 0) begin
            if (mac_entries < mlsl_pkg::TABLE_DEPTH) begin
                tbl_mac[mac_entries]  = f.src;
                mac_port[mac_entries] = f.ingress;
                mac_vld[mac_entries]  = 1'b1;
                mac_entries++;
                r.learned_new = 1'b1;
                n_learned++;
            end else begin
                r.table_full = 1'b1;
                n_full++;
            end
        end
        slot = find_mac(f.dst);
        if (slot >= 0) begin
            r.dest_known  = 1'b1;
            r.egress_mask = mlsl_pkg::MASK_W'(1) << mac_port[slot];
            n_hits++;
        end else begin
            active = (flood_port_count > mlsl_pkg::NUM_PORTS) ?
                     mlsl_pkg::NUM_PORTS : int'(flood_port_count);
            flood  = ((1 << active) - 1) & ~(1 << f.ingress);
            r.egress_mask = flood[mlsl_pkg::MASK_W-1:0];
            n_floods++;
        end
        return r;
    endfunction

    function automatic t_frame_hdr make_random_hdr(input int pool_lim);
        t_frame_hdr h;
        int pick;
        pick = $urandom_range(0, 99);
        h.src = (pick < 88) ? mac_pool[$urandom_range(0, pool_lim - 1)] : rand_mac();
        pick = $urandom_range(0, 99);
        if (pick < 50)
            h.dst = mac_pool[$urandom_range(0, pool_lim - 1)];
        else if (pick < 80)
            h.dst = rand_mac();
        else
            h.dst = h.src;
        h.ingress = mlsl_pkg::PORT_W'($urandom_range(0, mlsl_pkg::NUM_PORTS - 1));
        return h;
    endfunction

    task automatic push_frame(input logic [mlsl_pkg::MAC_W-1:0] s,
                              input logic [mlsl_pkg::MAC_W-1:0] d,
                              input logic [mlsl_pkg::PORT_W-1:0] p);
        hdr_pending_q.push_back('{src: s, dst: d, ingress: p});
        items_pushed++;
    endtask

    task automatic set_port_count(input logic [mlsl_pkg::PCNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        flood_port_count = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // block is idle once every pushed item has produced its result
    task automatic wait_drained();
        while (results_seen != items_pushed)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // item driver: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || hdr_taken)) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (hdr_pending_q.size() != 0) begin
                drv_hdr = hdr_pending_q.pop_front();
                i_source_mac   <= drv_hdr.src;
                i_dest_mac     <= drv_hdr.dst;
                i_ingress_port <= drv_hdr.ingress;
                i_in_valid     <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, switching between random stall patterns
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_pattern'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((stall_left % 9) < 4);
        endcase
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            hdr_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                seen_hdr = '{src: i_source_mac, dst: i_dest_mac, ingress: i_ingress_port};
                fwd_expected_q.push_back(predict_forwarding(seen_hdr));
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (fwd_expected_q.size() == 0) begin
                    $error("result with no item outstanding: mask %h", o_egress_mask);
                    err_count++;
                end else begin
                    want = fwd_expected_q.pop_front();
                    if (o_egress_mask !== want.egress_mask) begin
                        $error("egress_mask: expected %h, got %h",
                               want.egress_mask, o_egress_mask);
                        err_count++;
                    end
                    if (o_dest_known !== want.dest_known) begin
                        $error("dest_known: expected %b, got %b",
                               want.dest_known, o_dest_known);
                        err_count++;
                    end
                    if (o_learned_new !== want.learned_new) begin
                        $error("learned_new: expected %b, got %b",
                               want.learned_new, o_learned_new);
                        err_count++;
                    end
                    if (o_table_full !== want.table_full) begin
                        $error("table_full: expected %b, got %b",
                               want.table_full, o_table_full);
                        err_count++;
                    end
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [mlsl_pkg::PCNT_W-1:0] pc;
        t_frame_hdr h;
        for (int k = 0; k < POOL_SIZE; k++)
            mac_pool[k] = rand_mac();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset port count: extreme addresses, learning, hits and self-lookup
        push_frame('0, '1, 3'd0);
        push_frame('1, '0, 3'd7);
        push_frame('0, '1, 3'd3);
        push_frame(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 3'd5);
        push_frame(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 3'd2);
        push_frame(48'h5555_5555_5555, 48'h1234_5678_9ABC, 3'd7);
        push_frame(48'h0000_0000_0001, 48'h8000_0000_0000, 3'd4);
        wait_drained();

        // no active ports: floods reach nobody, hits still forward
        set_port_count(4'd0);
        push_frame('0, 48'h0F0F_0F0F_0F0F, 3'd0);
        push_frame(48'h0BAD_CAFE_0001, 48'h0BAD_CAFE_0001, 3'd6);
        push_frame(48'h5555_5555_5555, 48'hF0F0_F0F0_F0F0, 3'd1);
        wait_drained();

        // above the port limit: saturates to all ports
        set_port_count(4'd15);
        push_frame('1, 48'h0000_FFFF_0000, 3'd4);
        push_frame('1, 48'hFFFF_0000_FFFF, 3'd0);
        push_frame(48'h0000_0000_0001, 48'h7777_7777_7777, 3'd7);
        wait_drained();

        // ingress at or beyond the port count leaves the flood mask whole; below it, the ingress bit is cleared
        set_port_count(4'd3);
        push_frame('0, 48'h3333_3333_3333, 3'd5);
        push_frame('0, 48'h3333_3333_3333, 3'd1);
        push_frame('0, 48'h3333_3333_3333, 3'd2);
        push_frame('0, 48'h3333_3333_3333, 3'd3);
        wait_drained();

        // random traffic; the address pool grows past the table size so it fills up
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       pc = 4'd1;
                1:       pc = 4'd8;
                2:       pc = mlsl_pkg::PCNT_W'($urandom_range(2, 7));
                3:       pc = 4'd15;
                4:       pc = 4'd0;
                default: pc = 4'd6;
            endcase
            set_port_count(pc);
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                h = make_random_hdr(16 * (ph + 1));
                push_frame(h.src, h.dst, h.ingress);
            end
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (fwd_expected_q.size() != 0) begin
            $error("%0d results never arrived", fwd_expected_q.size());
            err_count++;
        end
        $display("Run covered %0d frames over %0d port count writes;", items_pushed, cfg_writes);
        $display("%0d sources learned, %0d refused; %0d destination hits, %0d floods",
                 n_learned, n_full, n_hits, n_floods);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- mac_learning_switch_lookup_unit.f -----
src/mlsl_pkg.sv
src/mlsl_cell.sv
src/mac_learning_switch_lookup_unit.sv
src/mlsl_checker.sv
verif/mac_learning_switch_lookup_unit_tb.sv
